### sv/csa_pkg.sv
`default_nettype none
package csa_pkg;
    localparam int MaxSeg = 32;
    localparam int IdxW = $clog2(MaxSeg);
    localparam int CntW = $clog2(MaxSeg + 1);
    localparam int LenW = 21;
    localparam int TimeW = 32;
    localparam int OwnW = 8;
    localparam int HoldW = 16;
    localparam int OffW = 20;
    localparam int SatW = 6;
    localparam logic [LenW-1:0] PoolMax = 21'd1048576;
    localparam logic [LenW-1:0] PoolReset = 21'd1024;

    localparam logic [1:0] FitFirst = 2'd0;
    localparam logic [1:0] FitBest = 2'd1;
    localparam logic [1:0] FitWorst = 2'd2;

    localparam logic [1:0] StAlloc = 2'd0;
    localparam logic [1:0] StNoFit = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StTick = 2'd3;

    localparam logic CfgFit = 1'b0;
    localparam logic CfgPool = 1'b1;

    // One table entry as stored in memory
    typedef struct packed {
        logic [LenW-1:0] len;
        logic busy;
        logic [OwnW-1:0] owner;
        logic [TimeW-1:0] rel;
    } t_seg;

    function automatic logic [SatW-1:0] sat63(input logic [CntW-1:0] v);
        logic [CntW:0] w;
        w = {1'b0, v};
        sat63 = (w > (CntW+1)'(63)) ? SatW'(63) : SatW'(w);
    endfunction
endpackage
`default_nettype wire

### sv/csa_ram.sv
`default_nettype none
module csa_ram #(
    parameter int Depth = 32,
    parameter int Width = 62
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/contiguous_segment_allocator_core.sv
// Passes: an allocate runs a search pass, a shift-up pass on a split, the entry writes and
//   a stats pass; a tick runs a release-and-merge pass and a stats pass; a zero-size request
//   runs only the stats pass. Search, tick and stats passes walk the table one entry a cycle
//   through a memory with one read port, one write port and a registered read.
// Throughput: one word in flight; the next is taken once the result leaves o_ side.
// Reset: synchronous, active low; a clearing pass over all 32 entries rebuilds the table
//   (no input word is taken meanwhile). A pool_size write starts the same pass.
`default_nettype none
module contiguous_segment_allocator_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_op,
    input  wire logic [7:0]                i_owner_id,
    input  wire logic [20:0]               i_request_size,
    input  wire logic [15:0]               i_hold_time,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [1:0]                     o_status,
    output logic [19:0]                    o_seg_offset,
    output logic [5:0]                     o_probe_count,
    output logic [5:0]                     o_released_count,
    output logic [20:0]                    o_free_total,
    output logic [20:0]                    o_largest_free,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [20:0]               i_cfg_data
);
    import csa_pkg::*;

    localparam int SegW = $bits(t_seg);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SRD    = 4'd2;  // search: read issued
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SHRD   = 4'd4;  // shift up for split
    localparam logic [3:0] S_SHWR   = 4'd5;
    localparam logic [3:0] S_WPICK  = 4'd6;
    localparam logic [3:0] S_TRD    = 4'd7;  // tick: release and merge
    localparam logic [3:0] S_TSCAN  = 4'd8;
    localparam logic [3:0] S_TFLUSH = 4'd9;
    localparam logic [3:0] S_STRD   = 4'd10; // stats pass
    localparam logic [3:0] S_STSCAN = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_fit;
    logic [LenW-1:0] r_pool;
    logic [TimeW-1:0] r_now;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] r_i;       // read pointer
    logic [CntW-1:0] r_w;       // write pointer / aux
    logic r_op;
    logic [OwnW-1:0] r_owner;
    logic [LenW-1:0] r_req;
    logic [HoldW-1:0] r_hold;
    logic r_found;
    logic [IdxW-1:0] r_pick;
    logic [LenW-1:0] r_plen;
    logic [CntW-1:0] r_probes;
    logic [CntW-1:0] r_rel_cnt;
    logic [OffW:0] r_off;
    logic [OffW:0] r_offacc;
    t_seg r_acc;                // merge accumulator
    logic r_acc_v;
    logic [LenW:0] r_tot;
    logic [LenW-1:0] r_big;
    logic [1:0] r_status;
    logic r_ovalid;

    logic we;
    logic [IdxW-1:0] waddr, raddr;
    t_seg wdata, rdata;
    logic [SegW-1:0] rdata_raw;

    csa_ram #(.Depth(MaxSeg), .Width(SegW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );
    assign rdata = t_seg'(rdata_raw);

    logic [LenW-1:0] cfg_pool;
    always_comb begin
        cfg_pool = i_cfg_data;
        if (i_cfg_data == '0) cfg_pool = LenW'(1);
        if (i_cfg_data > PoolMax) cfg_pool = PoolMax;
    end

    logic in_acc;
    logic cfg_we;
    // hold input words while a register write is offered
    assign o_stall = (r_state != S_IDLE) || r_ovalid || i_cfg_valid;
    assign in_acc = i_valid && !o_stall;
    assign o_cfg_ready = ((r_state == S_IDLE) && !r_ovalid) || (r_state == S_CLR);
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    logic fits;
    logic take;
    logic [LenW-1:0] rem;
    logic [TimeW:0] rel_sum;
    logic [TimeW-1:0] rel_sat;
    logic expire;
    t_seg cur;
    assign fits = !rdata.busy && (rdata.len >= r_req);
    assign rem = r_plen - r_req;
    assign rel_sum = {1'b0, r_now} + {{(TimeW-HoldW+1){1'b0}}, r_hold};
    assign rel_sat = rel_sum[TimeW] ? '1 : rel_sum[TimeW-1:0];
    assign expire = rdata.busy && (rdata.rel <= r_now);

    always_comb begin
        cur = rdata;
        if (expire) begin
            cur.busy = 1'b0;
        end
        take = 1'b0;
        if (fits) begin
            if (!r_found) take = 1'b1;
            else if (r_fit == FitBest) take = rdata.len <= r_plen;
            else if (r_fit == FitWorst) take = rdata.len >= r_plen;
        end
    end

    always_comb begin
        n_state = r_state;
        we = 1'b0;
        waddr = r_w[IdxW-1:0];
        wdata = '0;
        raddr = r_i[IdxW-1:0];
        case (r_state)
            S_CLR: begin
                we = 1'b1;
                wdata.len = (r_w == '0) ? r_pool : '0;
                if (r_w == CntW'(MaxSeg - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_op) n_state = S_TRD;
                    else if (i_request_size == '0) n_state = S_STRD;
                    else n_state = S_SRD;
                end
                raddr = '0;
            end
            S_SRD: n_state = S_SCAN;
            S_SCAN: begin
                if (r_i == r_cnt) begin
                    if (!r_found || (rem != '0 && r_cnt == CntW'(MaxSeg))) begin
                        n_state = S_STRD;
                    end else if (rem != '0 && r_cnt != CntW'(r_pick) + CntW'(1)) begin
                        n_state = S_SHRD;
                    end else begin
                        n_state = S_WPICK;
                    end
                end
                raddr = r_i[IdxW-1:0] + IdxW'(1);
            end
            S_SHRD: begin
                n_state = S_SHWR;
                raddr = r_w[IdxW-1:0] - IdxW'(1);
            end
            S_SHWR: begin
                // copy entry w-1 up to w
                we = 1'b1;
                waddr = r_w[IdxW-1:0];
                wdata = rdata;
                if (r_w == CntW'(r_pick) + CntW'(2)) n_state = S_WPICK;
                else n_state = S_SHRD;
                raddr = r_w[IdxW-1:0] - IdxW'(2);
            end
            S_WPICK: begin
                we = 1'b1;
                waddr = r_w[IdxW-1:0];
                if (r_w[IdxW-1:0] == r_pick) begin
                    wdata.len = r_req;
                    wdata.busy = 1'b1;
                    wdata.owner = r_owner;
                    wdata.rel = rel_sat;
                    n_state = S_STRD;
                end else begin
                    wdata.len = rem;
                end
                raddr = '0;
            end
            S_TRD: n_state = S_TSCAN;
            S_TSCAN: begin
                raddr = r_i[IdxW-1:0] + IdxW'(1);
                if (r_i != r_cnt && r_acc_v && !(!cur.busy && !r_acc.busy)) begin
                    we = 1'b1;
                    waddr = r_w[IdxW-1:0];
                    wdata = r_acc;
                end
                if (r_i == r_cnt) n_state = S_TFLUSH;
            end
            S_TFLUSH: begin
                we = 1'b1;
                waddr = r_w[IdxW-1:0];
                wdata = r_acc;
                raddr = '0;
                n_state = S_STRD;
            end
            S_STRD: n_state = S_STSCAN;
            S_STSCAN: begin
                raddr = r_i[IdxW-1:0] + IdxW'(1);
                if (r_i == r_cnt) n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (cfg_we && i_cfg_index == CfgPool) n_state = S_CLR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_fit <= FitFirst;
            r_pool <= PoolReset;
            r_now <= '0;
            r_cnt <= CntW'(1);
            r_w <= '0;
            r_i <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: r_w <= (cfg_we && i_cfg_index == CfgPool) ? '0 : r_w + CntW'(1);
                S_IDLE: begin
                    r_i <= '0;
                    r_w <= '0;
                    if (in_acc) begin
                        r_found <= 1'b0;
                        r_probes <= '0;
                        r_rel_cnt <= '0;
                        r_off <= '0;
                        r_offacc <= '0;
                        r_acc_v <= 1'b0;
                        r_tot <= '0;
                        r_big <= '0;
                        r_op <= i_op;
                        r_owner <= i_owner_id;
                        r_req <= i_request_size;
                        r_hold <= i_hold_time;
                        if (i_op && r_now != '1) r_now <= r_now + TimeW'(1);
                        if (!i_op && i_request_size == '0) begin
                            r_status <= StNoFit;
                        end
                    end
                end
                S_SRD: r_i <= r_i;
                S_SCAN: begin
                    if (r_i == r_cnt) begin
                        r_i <= '0;
                        if (!r_found) begin
                            r_status <= StNoFit;
                        end else if (rem != '0 && r_cnt == CntW'(MaxSeg)) begin
                            r_status <= StFull;
                            r_off <= '0;
                        end else begin
                            r_status <= StAlloc;
                            r_off <= r_off;
                            if (rem != '0) begin
                                r_w <= r_cnt;
                                r_cnt <= r_cnt + CntW'(1);
                            end else begin
                                r_w <= CntW'(r_pick);
                            end
                        end
                    end else begin
                        r_i <= r_i + CntW'(1);
                        if (take) begin
                            r_found <= 1'b1;
                            r_pick <= r_i[IdxW-1:0];
                            r_plen <= rdata.len;
                            r_off <= r_offacc;
                        end
                        r_offacc <= r_offacc + (OffW+1)'(rdata.len);
                        if (r_fit == FitBest || r_fit == FitWorst) begin
                            r_probes <= r_probes + CntW'(1);
                        end else if (!r_found && !fits) begin
                            r_probes <= r_probes + CntW'(1);
                        end
                    end
                end
                S_SHRD: r_w <= r_w;
                S_SHWR: r_w <= r_w - CntW'(1);
                S_WPICK: begin
                    if (r_w[IdxW-1:0] != r_pick) r_w <= CntW'(r_pick);
                    else r_i <= '0;
                end
                S_TSCAN: begin
                    if (r_i == r_cnt) begin
                        r_i <= '0;
                        r_cnt <= r_w + CntW'(1);
                        r_status <= StTick;
                    end else begin
                        r_i <= r_i + CntW'(1);
                        if (expire) r_rel_cnt <= r_rel_cnt + CntW'(1);
                        r_acc_v <= 1'b1;
                        if (r_acc_v && !cur.busy && !r_acc.busy) begin
                            r_acc.len <= r_acc.len + cur.len;
                        end else begin
                            r_acc <= cur;
                            if (r_acc_v) r_w <= r_w + CntW'(1);
                        end
                    end
                end
                S_TFLUSH: r_i <= '0;
                S_STSCAN: begin
                    if (r_i == r_cnt) begin
                        r_ovalid <= 1'b1;
                    end else begin
                        r_i <= r_i + CntW'(1);
                        if (!rdata.busy) begin
                            r_tot <= r_tot + (LenW+1)'(rdata.len);
                            if (rdata.len > r_big) r_big <= rdata.len;
                        end
                    end
                end
                default: r_w <= r_w;
            endcase
            if (cfg_we) begin
                if (i_cfg_index == CfgFit) r_fit <= i_cfg_data[1:0];
                else begin
                    r_pool <= cfg_pool;
                    r_cnt <= CntW'(1);
                end
            end
        end
    end

    always_comb begin
        o_valid = r_ovalid;
        o_status = r_status;
        o_seg_offset = (r_status == StAlloc) ? r_off[OffW-1:0] : '0;
        o_probe_count = r_op ? '0 : (r_req == '0 ? '0 : sat63(r_probes));
        o_released_count = r_op ? sat63(r_rel_cnt) : '0;
        o_free_total = r_tot[LenW-1:0];
        o_largest_free = r_big;
    end
endmodule
`default_nettype wire

### sv/csa_checker.sv
`default_nettype none
module csa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [19:0] o_seg_offset,
    input wire logic [5:0]  o_probe_count,
    input wire logic [5:0]  o_released_count,
    input wire logic [20:0] o_free_total,
    input wire logic [20:0] o_largest_free
);
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_seg_offset) &&
            $stable(o_probe_count) && $stable(o_free_total))
        else $error("result word changed while stalled");
    a_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_largest_free <= o_free_total)
        else $error("largest free above total");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result waits");
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd3 |-> o_released_count == 6'd0)
        else $error("release count on allocate");
endmodule

bind contiguous_segment_allocator_core csa_checker u_csa_checker (.*);
`default_nettype wire

### dv/tb_contiguous_segment_allocator_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_contiguous_segment_allocator_core;
    import csa_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [19:0] offset;
        logic [5:0]  probes;
        logic [5:0]  released;
        logic [20:0] free_total;
        logic [20:0] largest;
    } alloc_result_t;

    // Shadow of the allocator table; predicts one result word per input word
    class segment_scoreboard;
        int unsigned seg_len [MaxSeg];
        bit          seg_busy [MaxSeg];
        int unsigned seg_rel [MaxSeg];
        int unsigned seg_cnt;
        int unsigned now_ticks;
        int unsigned fit;
        int unsigned pool;
        alloc_result_t pending_results[$];
        int errors;

        function void rebuild();
            foreach (seg_len[i]) begin
                seg_len[i] = 0;
                seg_busy[i] = 0;
                seg_rel[i] = 0;
            end
            seg_len[0] = pool;
            seg_cnt = 1;
        endfunction

        function void reset_state();
            fit = 32'(FitFirst);
            pool = 32'(PoolReset);
            now_ticks = 0;
            errors = 0;
            rebuild();
        endfunction

        function void write_reg(logic idx, logic [20:0] data);
            int unsigned v;
            if (idx == CfgFit) begin
                fit = 32'(data[1:0]);
            end else begin
                v = 32'(data);
                if (v == 0) v = 1;
                if (v > 32'(PoolMax)) v = 32'(PoolMax);
                pool = v;
                rebuild();
            end
        endfunction

        function void note_input(logic op, logic [20:0] req, logic [15:0] hold);
            alloc_result_t r;
            int unsigned probes, released, pick, rem, t, m, w;
            longint unsigned rel;
            bit found;
            probes = 0; released = 0; pick = 0; found = 0;
            r.offset = 0;
            if (op) begin
                if (now_ticks != 32'hFFFF_FFFF) now_ticks++;
                for (int i = 0; i < seg_cnt; i++)
                    if (seg_busy[i] && seg_rel[i] <= now_ticks) begin
                        seg_busy[i] = 0;
                        released++;
                    end
                w = 0;
                for (int i = 0; i < seg_cnt; i++) begin
                    if (w > 0 && !seg_busy[i] && !seg_busy[w-1]) begin
                        seg_len[w-1] += seg_len[i];
                    end else begin
                        seg_len[w] = seg_len[i];
                        seg_busy[w] = seg_busy[i];
                        seg_rel[w] = seg_rel[i];
                        w++;
                    end
                end
                seg_cnt = w;
                r.status = StTick;
            end else if (req == 0) begin
                r.status = StNoFit;
            end else begin
                for (int i = 0; i < seg_cnt; i++) begin
                    bit fits;
                    fits = !seg_busy[i] && seg_len[i] >= req;
                    if (fit == FitBest || fit == FitWorst) begin
                        if (fits && (!found ||
                                (fit == FitBest && seg_len[i] <= seg_len[pick]) ||
                                (fit == FitWorst && seg_len[i] >= seg_len[pick]))) begin
                            pick = i;
                            found = 1;
                        end
                        probes++;
                    end else begin
                        if (fits) begin
                            pick = i;
                            found = 1;
                            break;
                        end
                        probes++;
                    end
                end
                if (!found) begin
                    r.status = StNoFit;
                end else begin
                    rem = seg_len[pick] - req;
                    if (rem > 0 && seg_cnt >= MaxSeg) begin
                        r.status = StFull;
                    end else begin
                        if (rem > 0) begin
                            for (int i = seg_cnt; i > pick + 1; i--) begin
                                seg_len[i] = seg_len[i-1];
                                seg_busy[i] = seg_busy[i-1];
                                seg_rel[i] = seg_rel[i-1];
                            end
                            seg_len[pick+1] = rem;
                            seg_busy[pick+1] = 0;
                            seg_rel[pick+1] = 0;
                            seg_cnt++;
                            seg_len[pick] = req;
                        end
                        rel = longint'(now_ticks) + hold;
                        seg_busy[pick] = 1;
                        seg_rel[pick] = (rel > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rel[31:0];
                        t = 0;
                        for (int i = 0; i < pick; i++) t += seg_len[i];
                        r.offset = t[19:0];
                        r.status = StAlloc;
                    end
                end
            end
            t = 0; m = 0;
            for (int i = 0; i < seg_cnt; i++)
                if (!seg_busy[i]) begin
                    t += seg_len[i];
                    if (seg_len[i] > m) m = seg_len[i];
                end
            r.probes = 6'((probes > 63) ? 63 : probes);
            r.released = 6'((released > 63) ? 63 : released);
            r.free_total = t[20:0];
            r.largest = m[20:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(alloc_result_t a);
            alloc_result_t e;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.offset !== e.offset) begin
                $error("seg_offset exp %0d got %0d", e.offset, a.offset); errors++;
            end
            if (a.probes !== e.probes) begin
                $error("probe_count exp %0d got %0d", e.probes, a.probes); errors++;
            end
            if (a.released !== e.released) begin
                $error("released_count exp %0d got %0d", e.released, a.released);
                errors++;
            end
            if (a.free_total !== e.free_total) begin
                $error("free_total exp %0d got %0d", e.free_total, a.free_total);
                errors++;
            end
            if (a.largest !== e.largest) begin
                $error("largest_free exp %0d got %0d", e.largest, a.largest); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_op = 0;
    logic [7:0]  in_owner = 0;
    logic [20:0] in_req = 0;
    logic [15:0] in_hold = 0;
    logic        out_stall = 0;
    logic        cfg_valid = 0;
    logic        cfg_index = 0;
    logic [20:0] cfg_data = 0;
    wire         in_stall, out_valid, cfg_ready;
    wire [1:0]   st;
    wire [19:0]  off;
    wire [5:0]   prb, rls;
    wire [20:0]  ftot, lfree;

    segment_scoreboard sb = new();
    bit stall_hold = 0;
    bit done = 0;
    int idle_cycles = 0;

    always begin
        #10 clk = 1;
        #10 clk = 0;
    end

    contiguous_segment_allocator_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_op(in_op), .i_owner_id(in_owner), .i_request_size(in_req),
        .i_hold_time(in_hold),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(st), .o_seg_offset(off), .o_probe_count(prb),
        .o_released_count(rls), .o_free_total(ftot), .o_largest_free(lfree),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // check result words and watch for a hang
    always @(posedge clk) begin
        alloc_result_t a;
        if (rst_n && out_valid && !out_stall) begin
            a.status = st; a.offset = off; a.probes = prb;
            a.released = rls; a.free_total = ftot; a.largest = lfree;
            sb.check_result(a);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk) begin
        if (stall_hold) out_stall <= 1;
        else if (done) out_stall <= 0;
        else case ($urandom_range(0, 3))
            0: out_stall <= ($urandom_range(0, 3) != 0);
            1: out_stall <= 0;
            default: out_stall <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_word(logic op, logic [7:0] own, logic [20:0] req, logic [15:0] hold);
        in_valid <= 1;
        in_op <= op; in_owner <= own; in_req <= req; in_hold <= hold;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, req, hold);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 0;
    endtask

    task automatic drain();
        drop_valid();
        while (sb.pending_results.size() != 0) @(negedge clk);
        // settle before the next phase
        repeat (120) @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [20:0] data);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
        repeat (40) @(negedge clk);
    endtask

    task automatic random_burst(int n, int unsigned pool);
        for (int i = 0; i < n; i++) begin
            logic [20:0] req;
            case ($urandom_range(0, 9))
                0: req = 21'($urandom_range(0, 21'h1FFFFF));
                1: req = 21'(pool);
                2, 3: req = 21'($urandom_range(1, pool));
                default: req = 21'($urandom_range(1, (pool > 16) ? pool / 16 : 1));
            endcase
            if ($urandom_range(0, 2) == 0)
                send_word(1, 8'($urandom), 21'($urandom), 16'($urandom));
            else
                send_word(0, 8'($urandom), req,
                          16'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 12)));
            // random gaps between words of a burst
            if ($urandom_range(0, 5) == 0) begin
                drop_valid();
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    endtask

    initial begin
        int unsigned pools[6];
        sb.reset_state();
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: reset config, extremes, zero request, table full
        send_word(0, 8'hFF, 0, 0);
        send_word(0, 8'h00, 21'h1FFFFF, 16'hFFFF);
        send_word(0, 8'hA5, 1024, 16'hFFFF);
        send_word(1, 0, 0, 0);
        send_word(0, 8'h5A, 10, 0);
        send_word(1, 0, 0, 0);
        for (int i = 0; i < 33; i++) send_word(0, 8'(i), 1, 3);
        send_word(1, 0, 0, 0);
        send_word(1, 8'hFF, 21'h1FFFFF, 16'hFFFF);
        send_word(1, 0, 0, 0);
        drain();
        write_cfg(CfgFit, 21'(FitBest));
        write_cfg(CfgPool, 0);
        send_word(0, 1, 1, 1);
        send_word(0, 1, 2, 1);
        drain();
        write_cfg(CfgPool, 21'h1FFFFF);
        send_word(0, 2, PoolMax, 5);
        send_word(0, 3, 1, 5);
        drain();

        // long receiver hold-off while words keep arriving
        fork
            begin
                stall_hold = 1;
                repeat (400) @(negedge clk);
                stall_hold = 0;
            end
            random_burst(10, 32'(PoolMax));
        join
        drain();

        pools = '{1024, 64, 1, 1048576, 300, 2048};
        for (int ph = 0; ph < 12; ph++) begin
            write_cfg(CfgFit, 21'(ph % 4));
            write_cfg(CfgPool, 21'(pools[ph % 6]));
            random_burst(50, sb.pool);
            drain();
        end

        done = 1;
        repeat (50) @(negedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
